>>> design/lpc_frame_speech_synthesizer_assert.svh
// ----------------------------------------------------------------------------
// LPC frame speech synthesizer assertion macros
// Shorthand for the concurrent checks in the synthesizer RTL.
// ----------------------------------------------------------------------------
`ifndef LPC_FRAME_SPEECH_SYNTHESIZER_ASSERT_SVH
`define LPC_FRAME_SPEECH_SYNTHESIZER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LFSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfss assertion failed");

// next-cycle implication
`define LFSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfss assertion failed");

`endif

>>> design/lfss_pkg.sv
// ----------------------------------------------------------------------------
// LPC frame speech synthesizer package
// Transaction types, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package lfss_pkg;

  typedef struct packed {
    logic        [7:0] pitch_period;
    logic        [7:0] gain_code;
    logic signed [7:0] refl_coef_0;
    logic signed [7:0] refl_coef_1;
    logic signed [7:0] refl_coef_2;
    logic signed [7:0] refl_coef_3;
    logic signed [7:0] refl_coef_4;
    logic signed [7:0] refl_coef_5;
    logic signed [7:0] refl_coef_6;
    logic signed [7:0] refl_coef_7;
    logic signed [7:0] refl_coef_8;
    logic signed [7:0] refl_coef_9;
  } lfss_in_t;

  typedef struct packed {
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
    logic signed [15:0] sample_third;
    logic signed [15:0] sample_fourth;
    logic               last_group;
  } lfss_out_t;

  typedef enum logic [23:0] {
    S_IDLE   = 24'h000001,
    S_GDIV   = 24'h000002,
    S_GSQRT  = 24'h000004,
    S_GMUL   = 24'h000008,
    S_PDIV   = 24'h000010,
    S_IGDIV  = 24'h000020,
    S_FINIT  = 24'h000040,
    S_SAMPLE = 24'h000080,
    S_NMUL1  = 24'h000100,
    S_NMUL2  = 24'h000200,
    S_RDIV1  = 24'h000400,
    S_RDIV2  = 24'h000800,
    S_PULSE  = 24'h001000,
    S_YDIV   = 24'h002000,
    S_SQ     = 24'h004000,
    S_POLY   = 24'h008000,
    S_PY     = 24'h010000,
    S_SV2    = 24'h020000,
    S_EXC    = 24'h040000,
    S_LSTART = 24'h080000,
    S_LA     = 24'h100000,
    S_LB     = 24'h200000,
    S_OUT    = 24'h400000,
    S_EMIT   = 24'h800000
  } lfss_state_e;

  localparam int DVD_W = 48;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = 64;
  localparam int DIG_W = 16;

  typedef struct packed {
    logic                      start;
    logic                      two;
    logic signed [MUL_A_W-1:0] a;
    logic        [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic             sqrt;
    logic [DVD_W-1:0] num;
    logic [5:0]       len;
  } div_req_t;

  localparam logic [5:0] LEN_GAIN   = 6'd48;
  localparam logic [5:0] LEN_PERIOD = 6'd24;
  localparam logic [5:0] LEN_GSTEP  = 6'd32;
  localparam logic [5:0] LEN_PULSE  = 6'd12;
  localparam logic [5:0] LEN_PHASE  = 6'd38;
  localparam logic [5:0] SQRT_STEPS = 6'd24;
  localparam logic [7:0] PULSE_DIV  = 8'd7;

  localparam logic [15:0] NOISE_SEED = 16'd2385;
  localparam logic [15:0] NOISE_TAPS = 16'hFFF6;
  localparam logic [15:0] NOISE_MSB  = 16'h8000;
  localparam logic signed [16:0] NOISE_OFS = 17'sd32768;
  localparam logic [31:0] NOISE_K = 32'd26008;

  localparam logic signed [23:0] Q22_MAX = 24'sd8388607;
  localparam logic signed [23:0] Q22_MIN = -24'sd8388608;
  localparam logic [22:0] CLIP_LIM = 23'd4193884;
  localparam logic [30:0] SIN_ONE = 31'h4000_0000;

  localparam logic signed [31:0] POLY_SEED = 32'sd172272;
  localparam logic signed [31:0] POLY_C [4] = '{
    -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
  };

endpackage

>>> design/lpc_frame_speech_synthesizer.sv
// ----------------------------------------------------------------------------
// LPC frame speech synthesizer
// Tenth-order lattice vocoder decoder: one coded frame in, one frame of
// 16-bit speech out in groups of four, one frame behind.
// ----------------------------------------------------------------------------
// A frame is taken only when the block is idle and produces
// ceil(SAMPLES_PER_FRAME/4) group transactions, the last one flagged. Frame
// setup runs a 48-step divider for the energy ratio, a 24-step square root
// and, when both pitch periods are nonzero, two step divisions. Unvoiced
// samples use the noise generator, voiced ones the bit-serial divider for
// the pulse phase and the sine polynomial; both then pass the ten lattice
// stages, all multiplies on one shared 34x17 digit-serial multiplier. A
// voiced sample that restarts the pitch period first runs the two 12-step
// divisions of the pulse rise and fall ends.
`include "lpc_frame_speech_synthesizer_assert.svh"

module lpc_frame_speech_synthesizer #(
  parameter int SAMPLES_PER_FRAME = 160,
  parameter int ENERGY_WINDOW = 240,
  parameter int FILTER_ORDER = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lfss_pkg::lfss_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lfss_pkg::lfss_out_t  out_data_o
);
  import lfss_pkg::*;

  localparam int DivMax = (ENERGY_WINDOW > SAMPLES_PER_FRAME) ? ENERGY_WINDOW
                                                              : SAMPLES_PER_FRAME;
  localparam int DvsW = $clog2(((DivMax > 255) ? DivMax : 255) + 1);
  localparam int SmpW = $clog2(SAMPLES_PER_FRAME);
  localparam int OrdW = $clog2(FILTER_ORDER);
  localparam int TapW = $clog2(FILTER_ORDER + 1);
  localparam logic [SmpW-1:0] LastSmp = SmpW'(SAMPLES_PER_FRAME - 1);
  localparam logic [OrdW-1:0] TopStage = OrdW'(FILTER_ORDER - 1);
  localparam logic [DvsW-1:0] EwDen = DvsW'(ENERGY_WINDOW);
  localparam logic [DvsW-1:0] SpfDen = DvsW'(SAMPLES_PER_FRAME);

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'(Q22_MAX)) return Q22_MAX;
    if (x < 64'(Q22_MIN)) return Q22_MIN;
    return x[23:0];
  endfunction

  // ---------------- state ----------------
  lfss_state_e state_q, state_d;
  lfss_in_t in_q, in_d;
  logic [7:0] prev_per_q, prev_per_d;
  logic [23:0] prev_gain_q, prev_gain_d;
  logic signed [7:0] prev_k_q [FILTER_ORDER];
  logic signed [7:0] prev_k_d [FILTER_ORDER];
  logic signed [7:0] new_k [FILTER_ORDER];
  logic signed [23:0] taps_q [FILTER_ORDER+1];
  logic signed [23:0] taps_d [FILTER_ORDER+1];
  logic [7:0] cd_q, cd_d, idx_q, idx_d, rise_q, rise_d, fall_q, fall_d;
  logic [15:0] noise_q, noise_d;
  logic [23:0] gnew_q, gnew_d;
  logic signed [25:0] inc_p_q, inc_p_d, acc_p_q, acc_p_d;
  logic signed [33:0] inc_g_q, inc_g_d, acc_g_q, acc_g_d;
  logic [30:0] y_q, y_d;
  logic [31:0] y2_q, y2_d;
  logic [1:0] pc_q, pc_d;
  logic risep_q, risep_d;
  logic signed [23:0] f_q, f_d;
  logic [OrdW-1:0] j_q, j_d;
  logic [SmpW-1:0] smp_q, smp_d;
  logic [1:0] pos_q, pos_d;
  logic signed [15:0] grp_q [4];
  logic signed [15:0] grp_d [4];
  logic fend_q, fend_d;
  logic out_valid_q, out_valid_d;
  lfss_out_t out_q, out_d;

  // ---------------- shared multiplier ----------------
  mul_req_t mul_req;
  logic signed [MUL_A_W-1:0] mul_a_q;
  logic [MUL_B_W-1:0] mul_b_q;
  logic [1:0] mul_left_q;
  logic mul_first_q;
  logic signed [MUL_P_W-1:0] mul_p_q;
  logic signed [DIG_W:0] mul_dig;
  logic signed [MUL_A_W+DIG_W:0] mul_part;
  logic signed [MUL_P_W-1:0] mul_next;

  assign mul_dig = mul_first_q ? {mul_b_q[MUL_B_W-1], mul_b_q[MUL_B_W-1 -: DIG_W]}
                               : {1'b0, mul_b_q[MUL_B_W-1 -: DIG_W]};
  assign mul_part = mul_a_q * mul_dig;
  assign mul_next = mul_first_q ? MUL_P_W'(mul_part)
                                : (mul_p_q <<< DIG_W) + MUL_P_W'(mul_part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_left_q <= '0;
    end else if (mul_req.start) begin
      mul_left_q <= mul_req.two ? 2'd2 : 2'd1;
    end else if (mul_left_q != '0) begin
      mul_left_q <= mul_left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_req.start) begin
      mul_a_q <= mul_req.a;
      mul_b_q <= mul_req.two ? mul_req.b : {mul_req.b[DIG_W-1:0], DIG_W'(0)};
      mul_first_q <= 1'b1;
    end else if (mul_left_q != '0) begin
      mul_p_q <= mul_next;
      mul_b_q <= {mul_b_q[MUL_B_W-DIG_W-1:0], DIG_W'(0)};
      mul_first_q <= 1'b0;
    end
  end

  // ---------------- bit-serial divider / square root ----------------
  div_req_t div_req;
  logic [DvsW-1:0] div_den;
  logic [DVD_W-1:0] dvd_q;
  logic [DvsW-1:0] rem_q, den_q;
  logic [26:0] sq_rem_q;
  logic [23:0] root_q;
  logic [5:0] div_left_q;
  logic sqrt_q;
  logic [DvsW:0] d_r2, d_sub;
  logic d_ge;
  logic [26:0] s_r2, s_trial;
  logic s_ge;

  assign d_r2 = {rem_q, dvd_q[DVD_W-1]};
  assign d_sub = d_r2 - {1'b0, den_q};
  assign d_ge = d_r2 >= {1'b0, den_q};
  assign s_r2 = {sq_rem_q[24:0], dvd_q[DVD_W-1 -: 2]};
  assign s_trial = {1'b0, root_q, 2'b01};
  assign s_ge = s_r2 >= s_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_left_q <= '0;
    end else if (div_req.start) begin
      div_left_q <= div_req.len;
    end else if (div_left_q != '0) begin
      div_left_q <= div_left_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      dvd_q <= div_req.num;
      rem_q <= '0;
      den_q <= div_den;
      sq_rem_q <= '0;
      root_q <= '0;
      sqrt_q <= div_req.sqrt;
    end else if (div_left_q != '0) begin
      if (sqrt_q) begin
        dvd_q <= {dvd_q[DVD_W-3:0], 2'b00};
        sq_rem_q <= s_ge ? (s_r2 - s_trial) : s_r2;
        root_q <= {root_q[22:0], s_ge};
      end else begin
        dvd_q <= {dvd_q[DVD_W-2:0], d_ge};
        rem_q <= d_ge ? d_sub[DvsW-1:0] : d_r2[DvsW-1:0];
      end
    end
  end

  // ---------------- sequencer ----------------
  logic mul_done, div_done;
  logic [23:0] gain;
  logic [7:0] peff;
  logic [8:0] pdiff;
  logic [7:0] pmag;
  logic [24:0] gdiff, gmag;
  logic [26:0] a3;
  logic [15:0] nz;
  logic signed [16:0] nval;
  logic [7:0] fd;
  logic signed [63:0] sh30;
  logic signed [33:0] pn;
  logic [22:0] fmag;
  logic [37:0] fscl;
  logic [15:0] smag;
  logic signed [15:0] sample;

  assign mul_done = (mul_left_q == '0);
  assign div_done = (div_left_q == '0);
  assign gain = acc_g_q[31:8];
  assign peff = (in_data_i.pitch_period != '0) ? in_data_i.pitch_period : 8'd3;
  assign pdiff = {1'b0, in_q.pitch_period} - {1'b0, prev_per_q};
  assign pmag = pdiff[8] ? 8'(-pdiff) : pdiff[7:0];
  assign gdiff = {1'b0, gnew_q} - {1'b0, prev_gain_q};
  assign gmag = gdiff[24] ? -gdiff : gdiff;
  assign a3 = {1'b0, acc_p_q[23:0], 1'b0} + {2'b0, acc_p_q[23:0]};
  assign nz = noise_q[0] ? (({1'b0, noise_q[15:1]} ^ NOISE_TAPS) | NOISE_MSB)
                         : {1'b0, noise_q[15:1]};
  assign nval = $signed({1'b0, nz}) - NOISE_OFS;
  assign fd = fall_q - (idx_q - rise_q);
  assign sh30 = mul_p_q >>> 30;
  assign pn = MUL_A_W'(POLY_C[pc_q]) + MUL_A_W'(sh30);
  assign fmag = (f_q < 0) ? ((-25'(f_q) > 25'(CLIP_LIM)) ? CLIP_LIM : 23'(-25'(f_q)))
                          : ((f_q > 24'(CLIP_LIM)) ? CLIP_LIM : f_q[22:0]);
  assign fscl = {fmag, 15'b0} - {15'b0, fmag};
  assign smag = fscl[37:22];
  assign sample = (f_q < 0) ? -$signed(smag) : $signed(smag);

  always_comb begin
    new_k[0] = in_q.refl_coef_0;
    new_k[1] = in_q.refl_coef_1;
    new_k[2] = in_q.refl_coef_2;
    new_k[3] = in_q.refl_coef_3;
    new_k[4] = in_q.refl_coef_4;
    new_k[5] = in_q.refl_coef_5;
    new_k[6] = in_q.refl_coef_6;
    new_k[7] = in_q.refl_coef_7;
    new_k[8] = in_q.refl_coef_8;
    new_k[9] = in_q.refl_coef_9;
  end

  always_comb begin
    state_d = state_q;
    in_d = in_q;
    prev_per_d = prev_per_q;
    prev_gain_d = prev_gain_q;
    prev_k_d = prev_k_q;
    taps_d = taps_q;
    cd_d = cd_q;
    idx_d = idx_q;
    rise_d = rise_q;
    fall_d = fall_q;
    noise_d = noise_q;
    gnew_d = gnew_q;
    inc_p_d = inc_p_q;
    inc_g_d = inc_g_q;
    acc_p_d = acc_p_q;
    acc_g_d = acc_g_q;
    y_d = y_q;
    y2_d = y2_q;
    pc_d = pc_q;
    risep_d = risep_q;
    f_d = f_q;
    j_d = j_q;
    smp_d = smp_q;
    pos_d = pos_q;
    grp_d = grp_q;
    fend_d = fend_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d = out_q;
    mul_req = '0;
    div_req = '0;
    div_den = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          state_d = S_GDIV;
        end
      end
      S_GDIV: begin
        if (div_done) begin
          // energy ratio ready, take its root
          div_req = '{start: 1'b1, sqrt: 1'b1, num: dvd_q, len: SQRT_STEPS};
          state_d = S_GSQRT;
        end
      end
      S_GSQRT: begin
        if (div_done) begin
          mul_req = '{start: 1'b1, two: 1'b0, a: MUL_A_W'(root_q),
                      b: MUL_B_W'(in_q.gain_code)};
          state_d = S_GMUL;
        end
      end
      S_GMUL: begin
        if (mul_done) begin
          gnew_d = (mul_p_q[63:8] > 56'hFF_FFFF) ? 24'hFF_FFFF : mul_p_q[31:8];
          if (prev_per_q != '0 && in_q.pitch_period != '0) begin
            div_req = '{start: 1'b1, sqrt: 1'b0,
                        num: {pmag, 16'b0, 24'b0}, len: LEN_PERIOD};
            div_den = SpfDen;
            state_d = S_PDIV;
          end else begin
            inc_p_d = '0;
            inc_g_d = '0;
            state_d = S_FINIT;
          end
        end
      end
      S_PDIV: begin
        if (div_done) begin
          inc_p_d = pdiff[8] ? -$signed({2'b0, dvd_q[23:0]}) : $signed({2'b0, dvd_q[23:0]});
          div_req = '{start: 1'b1, sqrt: 1'b0,
                      num: {gmag[23:0], 8'b0, 16'b0}, len: LEN_GSTEP};
          div_den = SpfDen;
          state_d = S_IGDIV;
        end
      end
      S_IGDIV: begin
        if (div_done) begin
          inc_g_d = gdiff[24] ? -$signed({2'b0, dvd_q[31:0]}) : $signed({2'b0, dvd_q[31:0]});
          state_d = S_FINIT;
        end
      end
      S_FINIT: begin
        acc_p_d = $signed({2'b0, prev_per_q, 16'b0});
        acc_g_d = $signed({2'b0, prev_gain_q, 8'b0});
        if (prev_per_q == '0) begin
          cd_d = '0;
          idx_d = '0;
          rise_d = '0;
          fall_d = '0;
        end
        smp_d = '0;
        pos_d = '0;
        state_d = S_SAMPLE;
      end
      S_SAMPLE: begin
        if (prev_per_q == '0) begin
          noise_d = nz;
          mul_req = '{start: 1'b1, two: 1'b0, a: MUL_A_W'(nval), b: NOISE_K};
          state_d = S_NMUL1;
        end else if (cd_q == '0) begin
          cd_d = acc_p_q[23:16];
          idx_d = '0;
          div_req = '{start: 1'b1, sqrt: 1'b0, num: {1'b0, a3[26:16], 36'b0},
                      len: LEN_PULSE};
          div_den = DvsW'(PULSE_DIV);
          state_d = S_RDIV1;
        end else begin
          state_d = S_PULSE;
        end
      end
      S_NMUL1: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, two: 1'b1, a: mul_p_q[MUL_A_W-1:0],
                      b: MUL_B_W'(gain)};
          state_d = S_NMUL2;
        end
      end
      S_NMUL2: begin
        if (mul_done) begin
          f_d = sat24(mul_p_q >>> 27);
          j_d = TopStage;
          state_d = S_LSTART;
        end
      end
      S_RDIV1: begin
        if (div_done) begin
          rise_d = dvd_q[7:0];
          div_req = '{start: 1'b1, sqrt: 1'b0, num: {a3[26:15], 36'b0}, len: LEN_PULSE};
          div_den = DvsW'(PULSE_DIV);
          state_d = S_RDIV2;
        end
      end
      S_RDIV2: begin
        if (div_done) begin
          fall_d = dvd_q[7:0];
          state_d = S_PULSE;
        end
      end
      S_PULSE: begin
        cd_d = cd_q - 8'd1;
        idx_d = idx_q + 8'd1;
        if (idx_q < rise_q) begin
          risep_d = 1'b1;
          div_req = '{start: 1'b1, sqrt: 1'b0, num: {idx_q, 40'b0}, len: LEN_PHASE};
          div_den = DvsW'(rise_q);
          state_d = S_YDIV;
        end else if (idx_q < fall_q) begin
          risep_d = 1'b0;
          div_req = '{start: 1'b1, sqrt: 1'b0, num: {fd, 40'b0}, len: LEN_PHASE};
          div_den = DvsW'(fall_q);
          state_d = S_YDIV;
        end else begin
          f_d = '0;
          j_d = TopStage;
          state_d = S_LSTART;
        end
      end
      S_YDIV: begin
        if (div_done) begin
          y_d = dvd_q[30:0];
          mul_req = '{start: 1'b1, two: 1'b1, a: MUL_A_W'(dvd_q[30:0]),
                      b: MUL_B_W'(dvd_q[30:0])};
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          y2_d = sh30[31:0];
          pc_d = '0;
          mul_req = '{start: 1'b1, two: 1'b1, a: MUL_A_W'(POLY_SEED), b: sh30[31:0]};
          state_d = S_POLY;
        end
      end
      S_POLY: begin
        if (mul_done) begin
          if (pc_q != 2'd3) begin
            pc_d = pc_q + 2'd1;
            mul_req = '{start: 1'b1, two: 1'b1, a: pn, b: y2_q};
          end else begin
            mul_req = '{start: 1'b1, two: 1'b1, a: pn, b: MUL_B_W'(y_q)};
            state_d = S_PY;
          end
        end
      end
      S_PY: begin
        if (mul_done) begin
          state_d = risep_q ? S_SV2 : S_EXC;
          if (sh30 < 0) begin
            mul_req = '{start: 1'b1, two: 1'b1, a: '0, b: '0};
          end else if (sh30 > 64'(SIN_ONE)) begin
            mul_req = '{start: 1'b1, two: 1'b1, a: MUL_A_W'(SIN_ONE),
                        b: risep_q ? MUL_B_W'(SIN_ONE) : MUL_B_W'(gain)};
          end else begin
            mul_req = '{start: 1'b1, two: 1'b1, a: MUL_A_W'(sh30[30:0]),
                        b: risep_q ? MUL_B_W'(sh30[30:0]) : MUL_B_W'(gain)};
          end
        end
      end
      S_SV2: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, two: 1'b1, a: MUL_A_W'(sh30), b: MUL_B_W'(gain)};
          state_d = S_EXC;
        end
      end
      S_EXC: begin
        if (mul_done) begin
          f_d = sat24(mul_p_q >>> 28);
          j_d = TopStage;
          state_d = S_LSTART;
        end
      end
      S_LSTART: begin
        mul_req = '{start: 1'b1, two: 1'b0, a: MUL_A_W'(taps_q[TapW'(j_q)]),
                    b: MUL_B_W'(prev_k_q[j_q])};
        state_d = S_LA;
      end
      S_LA: begin
        if (mul_done) begin
          f_d = sat24(64'(f_q) - (mul_p_q >>> 7));
          mul_req = '{start: 1'b1, two: 1'b0, a: MUL_A_W'(sat24(64'(f_q) - (mul_p_q >>> 7))),
                      b: MUL_B_W'(prev_k_q[j_q])};
          state_d = S_LB;
        end
      end
      S_LB: begin
        if (mul_done) begin
          taps_d[TapW'(j_q) + TapW'(1)] = sat24(64'(taps_q[TapW'(j_q)]) + (mul_p_q >>> 7));
          if (j_q == '0) begin
            taps_d[0] = f_q;
            state_d = S_OUT;
          end else begin
            j_d = j_q - OrdW'(1);
            state_d = S_LSTART;
          end
        end
      end
      S_OUT: begin
        grp_d[pos_q] = sample;
        fend_d = (smp_q == LastSmp);
        smp_d = smp_q + SmpW'(1);
        acc_p_d = acc_p_q + inc_p_q;
        acc_g_d = acc_g_q + inc_g_q;
        if (pos_q == 2'd3 || smp_q == LastSmp) begin
          state_d = S_EMIT;
        end else begin
          pos_d = pos_q + 2'd1;
          state_d = S_SAMPLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.sample_first = grp_q[0];
          out_d.sample_second = grp_q[1];
          out_d.sample_third = grp_q[2];
          out_d.sample_fourth = grp_q[3];
          out_d.last_group = fend_q;
          grp_d = '{default: '0};
          pos_d = '0;
          if (fend_q) begin
            // commit this frame's parameters for the next one
            prev_per_d = in_q.pitch_period;
            prev_gain_d = gnew_q;
            prev_k_d = new_k;
            state_d = S_IDLE;
          end else begin
            state_d = S_SAMPLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_IDLE && in_valid_i) begin
      div_req = '{start: 1'b1, sqrt: 1'b0, num: {peff, 40'b0}, len: LEN_GAIN};
      div_den = EwDen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prev_per_q <= '0;
      prev_gain_q <= '0;
      prev_k_q <= '{default: '0};
      taps_q <= '{default: '0};
      cd_q <= '0;
      idx_q <= '0;
      rise_q <= '0;
      fall_q <= '0;
      noise_q <= NOISE_SEED;
      grp_q <= '{default: '0};
      pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_per_q <= prev_per_d;
      prev_gain_q <= prev_gain_d;
      prev_k_q <= prev_k_d;
      taps_q <= taps_d;
      cd_q <= cd_d;
      idx_q <= idx_d;
      rise_q <= rise_d;
      fall_q <= fall_d;
      noise_q <= noise_d;
      grp_q <= grp_d;
      pos_q <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    gnew_q <= gnew_d;
    inc_p_q <= inc_p_d;
    inc_g_q <= inc_g_d;
    acc_p_q <= acc_p_d;
    acc_g_q <= acc_g_d;
    y_q <= y_d;
    y2_q <= y2_d;
    pc_q <= pc_d;
    risep_q <= risep_d;
    f_q <= f_d;
    j_q <= j_d;
    smp_q <= smp_d;
    fend_q <= fend_d;
    out_q <= out_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `LFSS_ASSERT_NOW(a_idle_units_quiet, in_ready_o, mul_done && div_done)
  `LFSS_ASSERT_NOW(a_mul_start_free, mul_req.start, mul_done)
  `LFSS_ASSERT_NOW(a_div_start_free, div_req.start, div_done)
  `LFSS_ASSERT_NOW(a_frame_ends_on_last, $rose(in_ready_o), out_valid_q && out_q.last_group)

endmodule
